// ===== src/sfs_pkg.sv =====
package sfs_pkg;

  localparam int unsigned MaxFrames = 64;
  localparam int unsigned FrameW    = 6;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CountW    = 7;
  localparam int unsigned CntdnW    = 18;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE      = 2'd0,
    MODE_LOOP      = 2'd1,
    MODE_PING_PONG = 2'd2,
    MODE_ONESHOT   = 2'd3
  } mode_e;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_DELAY = 3'd0,
    CFG_ANIM_MODE   = 3'd1,
    CFG_START_FRAME = 3'd2,
    CFG_END_FRAME   = 3'd3,
    CFG_FRAME_COUNT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              operation;
    logic [DelayW-1:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [ModeW-1:0]  active_mode;
    logic              oneshot_done;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_t;

endpackage

// ===== src/sfs_item_if.sv =====
interface sfs_item_if;
  logic          valid;
  logic          ready;
  sfs_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/sfs_result_if.sv =====
interface sfs_result_if;
  logic             valid;
  logic             ready;
  sfs_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/sfs_cfg_if.sv =====
interface sfs_cfg_if;
  logic          valid;
  logic          ready;
  sfs_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/sprite_frame_sequencer.sv =====
// Sprite animation frame sequencer. Register writes on the configuration
// channel are always accepted. A restart transaction goes from idle straight
// to the done state. A tick transaction passes through the subtract, loop and
// done states, because a single 18-bit adder first subtracts the elapsed time
// from the countdown and then adds the frame delay back once per advance. A
// tick with a zero frame delay goes straight to the done state. The result
// sits in an output register, so the next transaction is accepted while a
// finished result waits to be taken.
module sprite_frame_sequencer #(
  parameter int unsigned MaxFrames = sfs_pkg::MaxFrames
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfs_cfg_if.sink    cfg_i,
  sfs_item_if.sink   item_i,
  sfs_result_if.source result_o
);

  localparam int unsigned FrameW = sfs_pkg::FrameW;
  localparam int unsigned CntdnW = sfs_pkg::CntdnW;
  localparam int unsigned DelayW = sfs_pkg::DelayW;
  localparam int unsigned CountW = sfs_pkg::CountW;
  localparam int unsigned LimW   =
      ($clog2(MaxFrames + 1) > CountW) ? $clog2(MaxFrames + 1) : CountW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_LOOP,
    ST_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [DelayW-1:0]    frame_delay_q, frame_delay_d;
  sfs_pkg::mode_e       anim_mode_q, anim_mode_d;
  logic [FrameW-1:0]    start_frame_q, start_frame_d;
  logic [FrameW-1:0]    end_frame_q, end_frame_d;
  logic [CountW-1:0]    frame_count_q, frame_count_d;
  logic [FrameW-1:0]    cur_q, cur_d;
  logic                 down_q, down_d;
  logic [CntdnW-1:0]    cntdn_q, cntdn_d;
  sfs_pkg::mode_e       run_mode_q, run_mode_d;
  logic [DelayW-1:0]    elapsed_q, elapsed_d;
  logic                 done_q, done_d;
  logic                 out_valid_q, out_valid_d;
  sfs_pkg::result_t     out_q, out_d;

  logic [LimW-1:0]      lim_n;
  logic [LimW-1:0]      lim_last;
  logic [FrameW-1:0]    s_clamp, e_clamp, lo, hi;
  logic [CntdnW-1:0]    add_b, add_sum;
  logic                 item_acc, out_free;

  always_comb begin
    lim_n = LimW'(frame_count_q);
    if (lim_n == '0) begin
      lim_n = LimW'(1);
    end
    if (lim_n > LimW'(MaxFrames)) begin
      lim_n = LimW'(MaxFrames);
    end
    lim_last = lim_n - LimW'(1);
    s_clamp = (LimW'(start_frame_q) > lim_last) ? FrameW'(lim_last) : start_frame_q;
    e_clamp = (LimW'(end_frame_q) > lim_last) ? FrameW'(lim_last) : end_frame_q;
    lo = (s_clamp < e_clamp) ? s_clamp : e_clamp;
    hi = (s_clamp < e_clamp) ? e_clamp : s_clamp;
  end

  assign add_b   = (state_q == ST_SUB) ? (CntdnW'(0) - CntdnW'(elapsed_q))
                                       : CntdnW'(frame_delay_q);
  assign add_sum = cntdn_q + add_b;

  assign item_i.ready   = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;
  assign item_acc       = item_i.valid && item_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;

  always_comb begin
    state_d       = state_q;
    frame_delay_d = frame_delay_q;
    anim_mode_d   = anim_mode_q;
    start_frame_d = start_frame_q;
    end_frame_d   = end_frame_q;
    frame_count_d = frame_count_q;
    cur_d         = cur_q;
    down_d        = down_q;
    cntdn_d       = cntdn_q;
    run_mode_d    = run_mode_q;
    elapsed_d     = elapsed_q;
    done_d        = done_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.data.index)
        sfs_pkg::CFG_FRAME_DELAY: frame_delay_d = cfg_i.data.value[DelayW-1:0];
        sfs_pkg::CFG_ANIM_MODE:   anim_mode_d = sfs_pkg::mode_e'(cfg_i.data.value[1:0]);
        sfs_pkg::CFG_START_FRAME: start_frame_d = cfg_i.data.value[FrameW-1:0];
        sfs_pkg::CFG_END_FRAME:   end_frame_d = cfg_i.data.value[FrameW-1:0];
        sfs_pkg::CFG_FRAME_COUNT: frame_count_d = cfg_i.data.value[CountW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          done_d    = 1'b0;
          elapsed_d = item_i.data.elapsed;
          if (item_i.data.operation == sfs_pkg::OP_RESTART) begin
            down_d     = s_clamp > e_clamp;
            cntdn_d    = CntdnW'(frame_delay_q);
            run_mode_d = anim_mode_q;
            cur_d      = s_clamp;
            state_d    = ST_DONE;
          end else if (frame_delay_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SUB;
          end
        end
      end
      ST_SUB: begin
        cntdn_d = add_sum;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (cntdn_q[CntdnW-1]) begin
          cntdn_d = add_sum;
          unique case (run_mode_q)
            sfs_pkg::MODE_NONE: ;
            sfs_pkg::MODE_LOOP: begin
              cur_d = (cur_q >= hi) ? lo : cur_q + FrameW'(1);
            end
            sfs_pkg::MODE_PING_PONG: begin
              if (lo == hi) begin
                cur_d = lo;
              end else if (!down_q) begin
                if (cur_q >= hi) begin
                  down_d = 1'b1;
                  cur_d  = hi - FrameW'(1);
                end else begin
                  cur_d = cur_q + FrameW'(1);
                end
              end else begin
                if (cur_q <= lo) begin
                  down_d = 1'b0;
                  cur_d  = lo + FrameW'(1);
                end else begin
                  cur_d = cur_q - FrameW'(1);
                end
              end
            end
            sfs_pkg::MODE_ONESHOT: begin
              if (cur_q == e_clamp) begin
                run_mode_d = sfs_pkg::MODE_NONE;
                done_d     = 1'b1;
              end else if (cur_q < e_clamp) begin
                cur_d = cur_q + FrameW'(1);
              end else begin
                cur_d = cur_q - FrameW'(1);
              end
            end
          endcase
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.frame        = cur_q;
          out_d.active_mode  = run_mode_q;
          out_d.oneshot_done = done_q;
          state_d            = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_delay_q <= '0;
      anim_mode_q   <= sfs_pkg::MODE_NONE;
      start_frame_q <= '0;
      end_frame_q   <= '0;
      frame_count_q <= CountW'(1);
      cur_q         <= '0;
      down_q        <= 1'b0;
      cntdn_q       <= '0;
      run_mode_q    <= sfs_pkg::MODE_NONE;
      elapsed_q     <= '0;
      done_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      frame_delay_q <= frame_delay_d;
      anim_mode_q   <= anim_mode_d;
      start_frame_q <= start_frame_d;
      end_frame_q   <= end_frame_d;
      frame_count_q <= frame_count_d;
      cur_q         <= cur_d;
      down_q        <= down_d;
      cntdn_q       <= cntdn_d;
      run_mode_q    <= run_mode_d;
      elapsed_q     <= elapsed_d;
      done_q        <= done_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> !item_i.ready)
    else $error("item accepted while a transaction is in progress");

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.oneshot_done) |->
      (result_o.data.active_mode == sfs_pkg::MODE_NONE))
    else $error("one-shot finished but mode still armed");

  a_cntdn_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cntdn_q[CntdnW-1])
    else $error("countdown negative while idle");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (result_o.valid && state_q == ST_IDLE))
    else $error("finished transaction did not reach the output register");

endmodule

// ===== tb/sv/tb_sprite_frame_sequencer.sv =====
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  localparam int unsigned LimitCycles = 3_000_000;
  localparam int unsigned PhaseItems  = 130;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_ITEM,
    ROW_CHECKED
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_idx_e            idx;
    logic [DelayW-1:0]   value;
    op_e                 op;
    result_t             exp;
  } row_t;

  // The value column holds the register data for writes and the elapsed ticks for items.
  localparam int unsigned NumRows = 55;
  localparam row_t DirTable [NumRows] = '{
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_TICK,    '{6'd0, MODE_NONE, 1'b0}},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '{6'd0, MODE_NONE, 1'b0}},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '{6'd0, MODE_NONE, 1'b0}},
    '{ROW_WRITE,   CFG_FRAME_COUNT, 16'd64,    OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd63,    OP_TICK,    '0},
    '{ROW_WRITE,   CFG_FRAME_DELAY, 16'd1,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_ANIM_MODE,   16'(MODE_LOOP), OP_TICK, '0},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '{6'd0, MODE_LOOP, 1'b0}},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd0,     OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd2,     OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '0},
    '{ROW_WRITE,   CFG_ANIM_MODE,   16'(MODE_PING_PONG), OP_TICK, '0},
    '{ROW_WRITE,   CFG_START_FRAME, 16'd10,    OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd3,     OP_TICK,    '0},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '{6'd10, MODE_PING_PONG, 1'b0}},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd3,     OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd9,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_START_FRAME, 16'd5,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd5,     OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd1,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_ANIM_MODE,   16'(MODE_LOOP), OP_TICK, '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd4,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_START_FRAME, 16'd60,    OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd2,     OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd7,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_FRAME_COUNT, 16'd0,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_START_FRAME, 16'd63,    OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd63,    OP_TICK,    '0},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '{6'd0, MODE_LOOP, 1'b0}},
    '{ROW_WRITE,   CFG_FRAME_COUNT, 16'd127,   OP_TICK,    '0},
    '{ROW_WRITE,   CFG_ANIM_MODE,   16'(MODE_ONESHOT), OP_TICK, '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd0,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '0},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '{6'd63, MODE_ONESHOT, 1'b0}},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd1,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_FRAME_DELAY, 16'd1,     OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd70,    OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd5,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_START_FRAME, 16'd20,    OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd20,    OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd2,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_START_FRAME, 16'd0,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_END_FRAME,   16'd63,    OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd3,     OP_TICK,    '0},
    '{ROW_WRITE,   CFG_ANIM_MODE,   16'(MODE_NONE), OP_TICK, '0},
    '{ROW_WRITE,   CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '0},
    '{ROW_ITEM,    CFG_FRAME_DELAY, 16'd65535, OP_TICK,    '0},
    '{ROW_WRITE,   CFG_FRAME_COUNT, 16'd1,     OP_TICK,    '0},
    '{ROW_CHECKED, CFG_FRAME_DELAY, 16'd0,     OP_RESTART, '{6'd0, MODE_NONE, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  sfs_cfg_if    cfg_if ();
  sfs_item_if   item_if ();
  sfs_result_if res_if ();

  sprite_frame_sequencer u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (res_if)
  );

  // Register shadow and sequencer state as the design should hold them.
  logic [DelayW-1:0] reg_delay;
  mode_e             reg_mode;
  logic [FrameW-1:0] reg_start;
  logic [FrameW-1:0] reg_end;
  logic [CountW-1:0] reg_count;
  int unsigned       cur_frame;
  bit                going_down;
  int                countdown;
  mode_e             run_mode;

  result_t     expected_frames_q[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned restarts_sent;
  int unsigned ticks_sent;
  int unsigned reg_writes;
  int unsigned frame_advances;
  int unsigned oneshot_finishes;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_to_count(logic [FrameW-1:0] f);
    int unsigned n;
    n = reg_count;
    if (n == 0) n = 1;
    if (n > MaxFrames) n = MaxFrames;
    return (int'(f) > n - 1) ? n - 1 : int'(f);
  endfunction

  function automatic bit advance_frame();
    int unsigned s, e, lo, hi;
    s  = clamp_to_count(reg_start);
    e  = clamp_to_count(reg_end);
    lo = (s < e) ? s : e;
    hi = (s < e) ? e : s;
    case (run_mode)
      MODE_LOOP: begin
        cur_frame = (cur_frame >= hi) ? lo : cur_frame + 1;
      end
      MODE_PING_PONG: begin
        if (lo == hi) begin
          cur_frame = lo;
        end else if (!going_down) begin
          if (cur_frame >= hi) begin
            going_down = 1'b1;
            cur_frame  = hi - 1;
          end else begin
            cur_frame++;
          end
        end else begin
          if (cur_frame <= lo) begin
            going_down = 1'b0;
            cur_frame  = lo + 1;
          end else begin
            cur_frame--;
          end
        end
      end
      MODE_ONESHOT: begin
        if (cur_frame == e) begin
          run_mode = MODE_NONE;
          return 1'b1;
        end
        if (cur_frame < e) cur_frame++;
        else cur_frame--;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic result_t predict_frame(op_e op, logic [DelayW-1:0] elapsed);
    bit      finished;
    result_t r;
    finished = 1'b0;
    if (op == OP_RESTART) begin
      going_down = clamp_to_count(reg_start) > clamp_to_count(reg_end);
      countdown  = int'(reg_delay);
      run_mode   = reg_mode;
      cur_frame  = clamp_to_count(reg_start);
      restarts_sent++;
    end else begin
      ticks_sent++;
      if (reg_delay != 0) begin
        countdown -= int'(elapsed);
        while (countdown < 0) begin
          if (advance_frame()) finished = 1'b1;
          countdown += int'(reg_delay);
          frame_advances++;
        end
      end
    end
    if (finished) oneshot_finishes++;
    r.frame        = cur_frame[FrameW-1:0];
    r.active_mode  = run_mode;
    r.oneshot_done = finished;
    return r;
  endfunction

  task automatic send_item(op_e op, logic [DelayW-1:0] elapsed, bit fixed, result_t fixed_res);
    item_t   it;
    result_t predicted;
    it.operation = op;
    it.elapsed   = elapsed;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk_i); while (!item_if.ready);
    predicted = predict_frame(op, elapsed);
    expected_frames_q.push_back(fixed ? fixed_res : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_frames_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_t w;
    w.index = idx;
    w.value = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FRAME_DELAY: reg_delay = value[DelayW-1:0];
      CFG_ANIM_MODE:   reg_mode  = mode_e'(value[ModeW-1:0]);
      CFG_START_FRAME: reg_start = value[FrameW-1:0];
      CFG_END_FRAME:   reg_end   = value[FrameW-1:0];
      CFG_FRAME_COUNT: reg_count = value[CountW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [DelayW-1:0] pick_delay();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 10) return '1;
    if (roll < 40) return DelayW'($urandom_range(1, 8));
    if (roll < 80) return DelayW'($urandom_range(9, 300));
    return DelayW'($urandom_range(301, 65535));
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return CountW'($urandom_range(MaxFrames + 1, 127));
    if (roll < 24) return CountW'(1);
    return CountW'($urandom_range(2, MaxFrames));
  endfunction

  // Elapsed times mostly stay within six frame delays so that a tick causes few advances.
  function automatic logic [DelayW-1:0] pick_elapsed();
    int unsigned roll, span;
    roll = $urandom_range(99);
    if (reg_delay == 0 || (roll < 8 && reg_delay >= 2048)) return DelayW'($urandom);
    if (roll < 16) return '0;
    span = int'(reg_delay) * 6;
    if (span > 65535) span = 65535;
    return DelayW'($urandom_range(span));
  endfunction

  task automatic write_random_config(bit every_reg);
    drain_results();
    if (every_reg || $urandom_range(1)) write_reg(CFG_FRAME_DELAY, pick_delay());
    if (every_reg || $urandom_range(1)) write_reg(CFG_ANIM_MODE, CfgDataW'($urandom_range(3)));
    if (every_reg || $urandom_range(1)) write_reg(CFG_START_FRAME, CfgDataW'($urandom_range(63)));
    if (every_reg || $urandom_range(1)) write_reg(CFG_END_FRAME, CfgDataW'($urandom_range(63)));
    if (every_reg || $urandom_range(1)) write_reg(CFG_FRAME_COUNT, CfgDataW'(pick_count()));
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_frames
    result_t want;
    result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (expected_frames_q.size() == 0) begin
        $error("Result transaction with no expectation pending: frame %0d mode %0d done %0b",
               got.frame, got.active_mode, got.oneshot_done);
        mismatches++;
      end else begin
        want = expected_frames_q.pop_front();
        results_checked++;
        if (got.frame !== want.frame) begin
          $error("frame: expected %0d, got %0d", want.frame, got.frame);
          mismatches++;
        end
        if (got.active_mode !== want.active_mode) begin
          $error("active_mode: expected %0d, got %0d", want.active_mode, got.active_mode);
          mismatches++;
        end
        if (got.oneshot_done !== want.oneshot_done) begin
          $error("oneshot_done: expected %0b, got %0b", want.oneshot_done, got.oneshot_done);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Timeout after %0d cycles, %0d results still outstanding.",
               cycle_count, expected_frames_q.size());
      $display("** sprite_frame_sequencer: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned phase_stop;
    int unsigned burst;
    rst_ni        = 1'b0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    reg_delay     = '0;
    reg_mode      = MODE_NONE;
    reg_start     = '0;
    reg_end       = '0;
    reg_count     = CountW'(1);
    cur_frame     = 0;
    going_down    = 1'b0;
    countdown     = 0;
    run_mode      = MODE_NONE;
    send_idle_pct = 0;
    stall_pct     = 0;
    items_sent    = 0;
    restarts_sent = 0;
    ticks_sent    = 0;
    reg_writes    = 0;
    frame_advances   = 0;
    oneshot_finishes = 0;
    results_checked  = 0;
    mismatches    = 0;
    cycle_count   = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirTable[i]) begin
      case (DirTable[i].kind)
        ROW_WRITE: begin
          drain_results();
          write_reg(DirTable[i].idx, DirTable[i].value);
        end
        ROW_ITEM: send_item(DirTable[i].op, DirTable[i].value, 1'b0, '0);
        default:  send_item(DirTable[i].op, DirTable[i].value, 1'b1, DirTable[i].exp);
      endcase
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      phase_stop = items_sent + PhaseItems;
      write_random_config(1'b1);
      while (items_sent < phase_stop) begin
        if ($urandom_range(99) < 40) write_random_config(1'b0);
        if ($urandom_range(9) != 0) send_item(OP_RESTART, DelayW'($urandom), 1'b0, '0);
        burst = $urandom_range(3, 14);
        repeat (burst) begin
          send_item(op_e'(($urandom_range(19) == 0) ? OP_RESTART : OP_TICK), pick_elapsed(),
                    1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (expected_frames_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_frames_q.size());
      mismatches++;
    end

    $display("Checked %0d results over %0d transactions: %0d restarts, %0d ticks, %0d writes.",
             results_checked, items_sent, restarts_sent, ticks_sent, reg_writes);
    $display("The ticks caused %0d frame advances and %0d one-shot completions.",
             frame_advances, oneshot_finishes);
    if (mismatches == 0) begin
      $display("** sprite_frame_sequencer: PASSED **");
    end else begin
      $display("** sprite_frame_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
